@@ hdl/fully_assoc_lru_cache_classifier_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the LRU cache classifier.
// ---------------------------------------------------------------------------
`ifndef FULLY_ASSOC_LRU_CACHE_CLASSIFIER_MACROS_SVH
`define FULLY_ASSOC_LRU_CACHE_CLASSIFIER_MACROS_SVH

// same-cycle implication
`define FLC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("flc assertion failed");

// next-cycle implication
`define FLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("flc assertion failed");

`endif

@@ hdl/flc_pkg.sv @@
// ---------------------------------------------------------------------------
// flc_pkg
// Types and constants for the LRU cache classifier.
// ---------------------------------------------------------------------------
package flc_pkg;

  localparam int ADDR_W          = 16;
  localparam int CFG_W           = 5;
  localparam int CNT_W           = 32;
  localparam int OUTC_W          = 2;
  localparam int PADDR_W         = 3;
  localparam int PDATA_W         = 32;
  localparam int MAX_ENTRIES_DEF = 16;
  localparam int ADDR_BITS_DEF   = 16;

  localparam logic [CFG_W-1:0]     CFG_RESET         = CFG_W'(16);
  localparam logic [PADDR_W-3:0]   REG_CACHE_ENTRIES = '0;

  typedef enum logic [OUTC_W-1:0] {
    OUT_HIT        = 2'd0,
    OUT_COMPULSORY = 2'd1,
    OUT_CAPACITY   = 2'd2
  } outcome_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic match_en;
    logic commit;
    logic hit;
    logic evict;
    logic append;
  } cell_ctrl_t;

endpackage

@@ hdl/flc_cell.sv @@
// ---------------------------------------------------------------------------
// flc_cell
// One slot of the recency list: compare, shift toward oldest, load.
// ---------------------------------------------------------------------------
module flc_cell #(
  parameter int AW    = 16,
  parameter int OCC_W = 5,
  parameter int IDX   = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  flc_pkg::cell_ctrl_t ctrl_i,
  input  logic [OCC_W-1:0]    occ_i,
  input  logic [AW-1:0]       addr_i,
  input  logic [AW-1:0]       nxt_val_i,
  input  logic                sh_i,
  output logic [AW-1:0]       val_o,
  output logic                match_o,
  output logic                sh_o
);
  import flc_pkg::*;

  localparam logic [OCC_W-1:0] POS  = OCC_W'(IDX);
  localparam logic [OCC_W-1:0] POS1 = OCC_W'(IDX + 1);

  logic [AW-1:0] val_q, val_d;
  logic          match_q;
  logic          resident, is_last, is_tail, below_last, incl, take_next, load_addr;

  assign resident   = POS < occ_i;
  assign is_last    = POS1 == occ_i;
  assign is_tail    = POS == occ_i;
  assign below_last = POS1 < occ_i;
  assign incl       = sh_i | match_q;

  assign take_next = ctrl_i.commit & below_last &
                     ((ctrl_i.hit & incl) | ctrl_i.evict);
  assign load_addr = ctrl_i.commit &
                     ((is_last & (ctrl_i.hit | ctrl_i.evict)) | (is_tail & ctrl_i.append));

  always_comb begin
    val_d = val_q;
    if (load_addr) begin
      val_d = addr_i;
    end else if (take_next) begin
      val_d = nxt_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.match_en) begin
      match_q <= resident & (val_q == addr_i);
    end
  end

  assign val_o   = val_q;
  assign match_o = match_q;
  assign sh_o    = incl;

endmodule

@@ hdl/flc_seen_map.sv @@
// ---------------------------------------------------------------------------
// flc_seen_map
// One bit per address, swept to zero after reset, registered read.
// ---------------------------------------------------------------------------
module flc_seen_map #(
  parameter int AW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic          rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  output logic          clearing_o
);
  import flc_pkg::*;

  localparam int DEPTH = 2 ** AW;

  logic          mem [DEPTH];
  logic          clearing_q;
  logic [AW-1:0] clr_q;
  logic          rd_q;
  logic          we;
  logic [AW-1:0] wa;
  logic          wd;

  assign we = clearing_q | wr_en_i;
  assign wa = clearing_q ? clr_q : wr_addr_i;
  assign wd = ~clearing_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else if (clearing_q) begin
      clr_q <= clr_q + AW'(1);
      if (&clr_q) begin
        clearing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_q;
  assign clearing_o = clearing_q;

endmodule

@@ hdl/flc_stats.sv @@
// ---------------------------------------------------------------------------
// flc_stats
// Five saturating access counters.
// ---------------------------------------------------------------------------
module flc_stats (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    commit_i,
  input  logic                    hit_i,
  input  logic                    seen_i,
  output logic [flc_pkg::CNT_W-1:0] access_o,
  output logic [flc_pkg::CNT_W-1:0] hit_o,
  output logic [flc_pkg::CNT_W-1:0] miss_o,
  output logic [flc_pkg::CNT_W-1:0] compulsory_o,
  output logic [flc_pkg::CNT_W-1:0] capacity_o
);
  import flc_pkg::*;

  logic [CNT_W-1:0] acc_q, hit_q, miss_q, comp_q, cap_q;

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
    bump = (&c) ? c : c + CNT_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      hit_q  <= '0;
      miss_q <= '0;
      comp_q <= '0;
      cap_q  <= '0;
    end else if (commit_i) begin
      acc_q <= bump(acc_q);
      if (hit_i) begin
        hit_q <= bump(hit_q);
      end else begin
        miss_q <= bump(miss_q);
        if (seen_i) begin
          cap_q <= bump(cap_q);
        end else begin
          comp_q <= bump(comp_q);
        end
      end
    end
  end

  assign access_o     = acc_q;
  assign hit_o        = hit_q;
  assign miss_o       = miss_q;
  assign compulsory_o = comp_q;
  assign capacity_o   = cap_q;

endmodule

@@ hdl/fully_assoc_lru_cache_classifier.sv @@
// ---------------------------------------------------------------------------
// fully_assoc_lru_cache_classifier
// Fully associative LRU cache model with hit/compulsory/capacity classing.
// ---------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  in       | in_valid_i/ready_o   | address_i
//  out      | out_valid_o/ready_i  | outcome, evicted valid/address, totals
//  cfg      | APB psel/penable     | cache_entries at byte address 0
//
//  Each request passes a match state, in which every list cell compares,
//  then an update state that shifts the list; the seen bitmap is read when
//  the request is taken. After reset the seen bitmap is swept to zero, and
//  no request is taken until the sweep is done. A result waiting in the
//  output register stalls the update cycle; the next request is taken
//  in the cycle in which the update commits.
// ---------------------------------------------------------------------------
module fully_assoc_lru_cache_classifier #(
  parameter int MAX_ENTRIES = flc_pkg::MAX_ENTRIES_DEF,
  parameter int ADDR_BITS   = flc_pkg::ADDR_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [flc_pkg::ADDR_W-1:0]   address_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [flc_pkg::OUTC_W-1:0]   outcome_o,
  output logic                         evicted_valid_o,
  output logic [flc_pkg::ADDR_W-1:0]   evicted_address_o,
  output logic [flc_pkg::CNT_W-1:0]    access_total_o,
  output logic [flc_pkg::CNT_W-1:0]    hit_total_o,
  output logic [flc_pkg::CNT_W-1:0]    miss_total_o,
  output logic [flc_pkg::CNT_W-1:0]    compulsory_total_o,
  output logic [flc_pkg::CNT_W-1:0]    capacity_total_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [flc_pkg::PADDR_W-1:0]  paddr,
  input  logic [flc_pkg::PDATA_W-1:0]  pwdata,
  output logic [flc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import flc_pkg::*;

`include "fully_assoc_lru_cache_classifier_macros.svh"

  localparam int AW    = ADDR_BITS;
  localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
  localparam int LIM_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;

  state_e           state_q, state_d;
  logic [CFG_W-1:0] cfg_q;
  logic [OCC_W-1:0] occ_q;
  logic [AW-1:0]    addr_q, addr_in;
  logic             fwd_q, seen_rd, seen, clearing;
  logic             out_valid_q;
  outcome_e         outcome_q;
  logic             ev_valid_q;
  logic [ADDR_W-1:0] ev_addr_q, ev_addr_ext;
  logic             out_free, commit, in_fire, found, has_room;
  logic [LIM_W-1:0] cfg_ext, limit;
  cell_ctrl_t       ctrl;

  logic [AW-1:0]        vals  [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] match_vec;
  logic [MAX_ENTRIES:0] sh_chain;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == REG_CACHE_ENTRIES) ?
                  PDATA_W'(cfg_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[PADDR_W-1:2] == REG_CACHE_ENTRIES) begin
      cfg_q <= pwdata[CFG_W-1:0];
    end
  end

  // address width adaptation
  if (AW <= ADDR_W) begin : g_addr_narrow
    assign addr_in     = address_i[AW-1:0];
    assign ev_addr_ext = ADDR_W'(vals[0]);
  end else begin : g_addr_wide
    assign addr_in     = {{(AW-ADDR_W){1'b0}}, address_i};
    assign ev_addr_ext = vals[0][ADDR_W-1:0];
  end

  // size limit, clamped to 1..MAX_ENTRIES
  always_comb begin
    cfg_ext = LIM_W'(cfg_q);
    if (cfg_ext == '0) begin
      limit = LIM_W'(1);
    end else if (cfg_ext > LIM_W'(MAX_ENTRIES)) begin
      limit = LIM_W'(MAX_ENTRIES);
    end else begin
      limit = cfg_ext;
    end
  end

  assign has_room = LIM_W'(occ_q) < limit;
  assign found    = |match_vec;
  assign seen     = seen_rd | fwd_q;

  assign out_free   = ~out_valid_q | out_ready_i;
  assign commit     = (state_q == ST_UPDATE) & out_free;
  assign in_ready_o = (state_q == ST_IDLE) | commit;
  assign in_fire    = in_valid_i & in_ready_o;

  assign ctrl.match_en = state_q == ST_MATCH;
  assign ctrl.commit   = commit;
  assign ctrl.hit      = found;
  assign ctrl.evict    = ~found & ~has_room;
  assign ctrl.append   = ~found & has_room;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (!clearing) state_d = ST_IDLE;
      ST_IDLE:   if (in_fire) state_d = ST_MATCH;
      ST_MATCH:  state_d = ST_UPDATE;
      ST_UPDATE: begin
        if (commit) begin
          state_d = in_fire ? ST_MATCH : ST_IDLE;
        end
      end
      default:   state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (commit && ctrl.append) begin
        occ_q <= occ_q + OCC_W'(1);
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      addr_q <= addr_in;
      fwd_q  <= commit & (addr_in == addr_q);
    end
    if (commit) begin
      outcome_q  <= found ? OUT_HIT : (seen ? OUT_CAPACITY : OUT_COMPULSORY);
      ev_valid_q <= ctrl.evict;
      ev_addr_q  <= ctrl.evict ? ev_addr_ext : '0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign outcome_o         = outcome_q;
  assign evicted_valid_o   = ev_valid_q;
  assign evicted_address_o = ev_addr_q;

  // recency list
  assign sh_chain[0] = 1'b0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [AW-1:0] nxt;
    if (i < MAX_ENTRIES - 1) begin : g_mid
      assign nxt = vals[i+1];
    end else begin : g_end
      assign nxt = '0;
    end
    flc_cell #(
      .AW    (AW),
      .OCC_W (OCC_W),
      .IDX   (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .occ_i     (occ_q),
      .addr_i    (addr_q),
      .nxt_val_i (nxt),
      .sh_i      (sh_chain[i]),
      .val_o     (vals[i]),
      .match_o   (match_vec[i]),
      .sh_o      (sh_chain[i+1])
    );
  end

  flc_seen_map #(
    .AW (AW)
  ) u_seen (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_fire),
    .rd_addr_i  (addr_in),
    .rd_data_o  (seen_rd),
    .wr_en_i    (commit),
    .wr_addr_i  (addr_q),
    .clearing_o (clearing)
  );

  flc_stats u_stats (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .commit_i     (commit),
    .hit_i        (found),
    .seen_i       (seen),
    .access_o     (access_total_o),
    .hit_o        (hit_total_o),
    .miss_o       (miss_total_o),
    .compulsory_o (compulsory_total_o),
    .capacity_o   (capacity_total_o)
  );

  // assertions
  `FLC_ASSERT_NOW(a_unique_match, clk_i, rst_ni, 1'b1, $onehot0(match_vec))
  `FLC_ASSERT_NOW(a_no_req_clearing, clk_i, rst_ni, clearing, !in_ready_o)
  `FLC_ASSERT_NOW(a_evict_is_miss, clk_i, rst_ni, out_valid_q && ev_valid_q, outcome_q != OUT_HIT)
  `FLC_ASSERT_NEXT(a_append_grows, clk_i, rst_ni, commit && ctrl.append, occ_q == $past(occ_q) + OCC_W'(1))

endmodule
